FILE: src/tplc_pkg.sv
`default_nettype none
package tplc_pkg;

	localparam int unsigned KIND_W     = 2;
	localparam int unsigned ADC_W      = 12;
	localparam int unsigned TIME_W     = 32;
	localparam int unsigned LEVEL_W    = 7;
	localparam int unsigned IND_W      = 2;
	localparam int unsigned DEBOUNCE_W = 24;
	localparam int unsigned CFG_IDX_W  = 8;

	localparam logic [KIND_W-1:0] KIND_SAMPLE  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_FILL    = 2'd1;
	localparam logic [KIND_W-1:0] KIND_DRAIN   = 2'd2;
	localparam logic [KIND_W-1:0] KIND_DISPLAY = 2'd3;

	localparam logic [IND_W-1:0] IND_NORMAL  = 2'd0;
	localparam logic [IND_W-1:0] IND_ALARM   = 2'd1;
	localparam logic [IND_W-1:0] IND_PUMPING = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEVEL     = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEVEL     = 8'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_TIME = 8'd2;

	localparam logic [LEVEL_W-1:0]    MIN_LEVEL_RST     = 7'd0;
	localparam logic [LEVEL_W-1:0]    MAX_LEVEL_RST     = 7'd80;
	localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_TIME_RST = 24'd200000;

	localparam logic [ADC_W:0]     ADC_FULL_SCALE = 13'd4095;
	localparam logic [LEVEL_W-1:0] PCT_FULL       = 7'd60;
	localparam logic [LEVEL_W-1:0] PCT_EMPTY      = 7'd81;
	localparam logic [LEVEL_W-1:0] LEVEL_FULL     = 7'd100;
	localparam logic [LEVEL_W-1:0] LEVEL_EMPTY    = 7'd0;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [ADC_W-1:0]  adc_sample;
		logic [TIME_W-1:0] time_us;
	} in_item_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] level;
		logic               filling;
		logic               draining;
		logic               pump_on;
		logic               safety_active;
		logic               display_mode;
		logic [IND_W-1:0]   indicator;
		logic               fill_wave_pulse;
		logic               drain_wave_pulse;
	} out_item_t;

	// classified beat: samples carry the mapped level, buttons their timestamp
	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [LEVEL_W-1:0] level;
		logic [TIME_W-1:0]  time_us;
	} cls_item_t;

	// percent -> level; between the full and empty marks this is (81-p)*100/21
	function automatic logic [LEVEL_W-1:0] pct_to_level(input logic [LEVEL_W-1:0] p);
		logic [LEVEL_W-1:0] lv;
		lv = LEVEL_EMPTY;
		if (p >= PCT_EMPTY) begin
			lv = LEVEL_EMPTY;
		end else if (p <= PCT_FULL) begin
			lv = LEVEL_FULL;
		end else begin
			case (p)
				7'd61:   lv = 7'd95;
				7'd62:   lv = 7'd90;
				7'd63:   lv = 7'd85;
				7'd64:   lv = 7'd80;
				7'd65:   lv = 7'd76;
				7'd66:   lv = 7'd71;
				7'd67:   lv = 7'd66;
				7'd68:   lv = 7'd61;
				7'd69:   lv = 7'd57;
				7'd70:   lv = 7'd52;
				7'd71:   lv = 7'd47;
				7'd72:   lv = 7'd42;
				7'd73:   lv = 7'd38;
				7'd74:   lv = 7'd33;
				7'd75:   lv = 7'd28;
				7'd76:   lv = 7'd23;
				7'd77:   lv = 7'd19;
				7'd78:   lv = 7'd14;
				7'd79:   lv = 7'd9;
				7'd80:   lv = 7'd4;
				default: lv = LEVEL_EMPTY;
			endcase
		end
		return lv;
	endfunction

endpackage
`default_nettype wire

FILE: src/tplc_front.sv
`default_nettype none
module tplc_front import tplc_pkg::*; (
	input  wire in_item_t  item,
	output cls_item_t      cls
);

	logic [18:0]        scaled;
	logic [LEVEL_W-1:0] q0;
	logic [ADC_W:0]     rem;
	logic [LEVEL_W-1:0] pct;

	// adc*100/4095: take the quotient by 4096, then one correction step
	always_comb begin
		scaled = 19'(item.adc_sample) * 19'd100;
		q0     = scaled[18:12];
		rem    = {1'b0, scaled[11:0]} + 13'(q0);
		pct    = q0 + ((rem >= ADC_FULL_SCALE) ? 7'd1 : 7'd0);
	end

	always_comb begin
		cls.kind    = item.kind;
		cls.time_us = item.time_us;
		cls.level   = (item.kind == KIND_SAMPLE) ? pct_to_level(pct) : LEVEL_EMPTY;
	end

endmodule
`default_nettype wire

FILE: src/tplc_queue.sv
`default_nettype none
module tplc_queue import tplc_pkg::*; (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            wr_en,
	input  wire cls_item_t wr_item,
	output logic           full,
	output logic           rd_valid,
	output cls_item_t      rd_item,
	input  wire            rd_pop
);

	cls_item_t  mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       do_wr;
	logic       do_rd;

	assign full     = (cnt_q == 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_item  = mem_q[rd_ptr_q];
	assign do_wr    = wr_en && !full;
	assign do_rd    = rd_pop && rd_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_rd) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({do_wr, do_rd})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("queue count overflow");

	a_wr_full: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && full && !do_rd) |=> full)
		else $error("queue lost its full state on a refused beat");

endmodule
`default_nettype wire

FILE: src/tplc_back.sv
`default_nettype none
module tplc_back import tplc_pkg::*; (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 cfg_valid,
	output logic                cfg_ready,
	input  wire [CFG_IDX_W-1:0] cfg_index,
	input  wire [DEBOUNCE_W-1:0] cfg_data,
	input  wire                 q_valid,
	input  wire cls_item_t      q_item,
	output logic                q_pop,
	output logic                empty,
	input  wire                 pop,
	output out_item_t           result
);

	logic [LEVEL_W-1:0]    min_level_q;
	logic [LEVEL_W-1:0]    max_level_q;
	logic [DEBOUNCE_W-1:0] debounce_q;

	logic [LEVEL_W-1:0] level_q;
	logic               fill_q;
	logic               drain_q;
	logic               pump_q;
	logic               safety_q;
	logic               screen_q;
	logic [TIME_W-1:0]  last_press_q;
	logic [IND_W-1:0]   ind_q;

	logic [LEVEL_W-1:0] level_n;
	logic               fill_n;
	logic               drain_n;
	logic               pump_n;
	logic               safety_n;
	logic               screen_n;
	logic [TIME_W-1:0]  last_press_n;
	logic [IND_W-1:0]   ind_n;
	logic               pa;
	logic               pb;
	logic [TIME_W-1:0]  dt;

	out_item_t  ob_q [2];
	logic       ob_wr_q;
	logic       ob_rd_q;
	logic [1:0] ob_cnt_q;
	logic       adv;
	logic       ob_pop;
	out_item_t  res_n;

	assign cfg_ready = 1'b1;
	assign adv       = q_valid && (ob_cnt_q != 2'd2);
	assign q_pop     = adv;
	assign empty     = (ob_cnt_q == 2'd0);
	assign ob_pop    = pop && !empty;
	assign result    = ob_q[ob_rd_q];

	always_comb begin
		level_n      = level_q;
		fill_n       = fill_q;
		drain_n      = drain_q;
		pump_n       = pump_q;
		safety_n     = safety_q;
		screen_n     = screen_q;
		last_press_n = last_press_q;
		ind_n        = ind_q;
		pa           = 1'b0;
		pb           = 1'b0;
		dt           = q_item.time_us - last_press_q;

		if (q_item.kind == KIND_SAMPLE) begin
			level_n = q_item.level;
			if (level_n < min_level_q || level_n > max_level_q) begin
				ind_n = IND_ALARM;
			end else if (drain_q || fill_q) begin
				ind_n = IND_PUMPING;
			end else begin
				ind_n = IND_NORMAL;
			end
			// safety: start a correction, or stop the opposing pump first
			if (level_n < min_level_q && !fill_n) begin
				if (drain_n) begin
					drain_n = 1'b0;
					pb      = !pb;
				end else begin
					fill_n   = 1'b1;
					pump_n   = 1'b1;
					safety_n = 1'b1;
					pa       = !pa;
				end
			end else if (level_n > max_level_q && !drain_n) begin
				if (fill_n) begin
					fill_n = 1'b0;
					pa     = !pa;
				end else begin
					drain_n  = 1'b1;
					pump_n   = 1'b1;
					safety_n = 1'b1;
					pb       = !pb;
				end
			end
			if (safety_n) begin
				if (level_n >= min_level_q && fill_n) begin
					fill_n   = 1'b0;
					pump_n   = 1'b0;
					safety_n = 1'b0;
					pa       = !pa;
				end else if (level_n <= max_level_q && drain_n) begin
					drain_n  = 1'b0;
					pump_n   = 1'b0;
					safety_n = 1'b0;
					pb       = !pb;
				end
			end
		end else if (dt > {8'd0, debounce_q}) begin
			if (q_item.kind == KIND_DISPLAY) begin
				screen_n = !screen_q;
			end
			// during safety the press leaves the timestamp alone
			if (!safety_q) begin
				if (q_item.kind == KIND_FILL && !drain_q && level_q < max_level_q) begin
					fill_n = !fill_q;
					pump_n = !pump_q;
					pa     = 1'b1;
				end else if (q_item.kind == KIND_DRAIN && !fill_q
						&& level_q > min_level_q) begin
					drain_n = !drain_q;
					pump_n  = !pump_q;
					pb      = 1'b1;
				end
				last_press_n = q_item.time_us;
			end
		end

		res_n.level            = level_n;
		res_n.filling          = fill_n;
		res_n.draining         = drain_n;
		res_n.pump_on          = pump_n;
		res_n.safety_active    = safety_n;
		res_n.display_mode     = screen_n;
		res_n.indicator        = ind_n;
		res_n.fill_wave_pulse  = pa;
		res_n.drain_wave_pulse = pb;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_level_q  <= MIN_LEVEL_RST;
			max_level_q  <= MAX_LEVEL_RST;
			debounce_q   <= DEBOUNCE_TIME_RST;
			level_q      <= '0;
			fill_q       <= 1'b0;
			drain_q      <= 1'b0;
			pump_q       <= 1'b0;
			safety_q     <= 1'b0;
			screen_q     <= 1'b1;
			last_press_q <= '0;
			ind_q        <= IND_NORMAL;
			ob_wr_q      <= 1'b0;
			ob_rd_q      <= 1'b0;
			ob_cnt_q     <= 2'd0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_MIN_LEVEL:     min_level_q <= cfg_data[LEVEL_W-1:0];
					CFG_MAX_LEVEL:     max_level_q <= cfg_data[LEVEL_W-1:0];
					CFG_DEBOUNCE_TIME: debounce_q  <= cfg_data;
					default: ;
				endcase
			end
			if (adv) begin
				level_q      <= level_n;
				fill_q       <= fill_n;
				drain_q      <= drain_n;
				pump_q       <= pump_n;
				safety_q     <= safety_n;
				screen_q     <= screen_n;
				last_press_q <= last_press_n;
				ind_q        <= ind_n;
				ob_wr_q      <= !ob_wr_q;
			end
			if (ob_pop) begin
				ob_rd_q <= !ob_rd_q;
			end
			case ({adv, ob_pop})
				2'b10:   ob_cnt_q <= ob_cnt_q + 2'd1;
				2'b01:   ob_cnt_q <= ob_cnt_q - 2'd1;
				default: ob_cnt_q <= ob_cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ob_q[ob_wr_q] <= res_n;
		end
	end

	a_pumps_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(fill_q && drain_q))
		else $error("fill and drain pumps both running");

	a_safety_pump: assert property (@(posedge clk) disable iff (!arst_n)
		safety_q |-> pump_q)
		else $error("safety active without pump flag");

	a_pulse_match: assert property (@(posedge clk) disable iff (!arst_n)
		adv |-> (pa == (fill_n != fill_q)) && (pb == (drain_n != drain_q)))
		else $error("wave pulse does not match pump change");

	a_ob_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ob_cnt_q != 2'd3)
		else $error("result buffer overflow");

endmodule
`default_nettype wire

FILE: src/tank_pump_level_controller_core.sv
`default_nettype none
// Tank pump level controller. One beat is taken per clock while full is low, and one
// result beat comes out for each, in order. A pushed beat is stored in the queue; the back
// end then registers its result into the output buffer, a step that waits while that
// buffer is full, and the result is popped from there. Sustained throughput is one beat
// per cycle while results are popped, set by the back end, which updates its state as it
// takes each beat. The front end scales the sensor reading and feeds a two-entry queue; the
// back end owns the pump state and the configuration registers and writes results into a
// two-entry output buffer, so input keeps flowing while one result waits to be popped.
// Configuration is always ready; write it only while the block is idle.
module tank_pump_level_controller_core import tplc_pkg::*; (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  push,
	output logic                 full,
	input  wire in_item_t        item,
	output logic                 empty,
	input  wire                  pop,
	output out_item_t            result,
	input  wire                  cfg_valid,
	output logic                 cfg_ready,
	input  wire [CFG_IDX_W-1:0]  cfg_index,
	input  wire [DEBOUNCE_W-1:0] cfg_data
);

	cls_item_t cls;
	cls_item_t q_item;
	logic      q_valid;
	logic      q_pop;

	tplc_front u_front (
		.item (item),
		.cls  (cls)
	);

	tplc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (push),
		.wr_item  (cls),
		.full     (full),
		.rd_valid (q_valid),
		.rd_item  (q_item),
		.rd_pop   (q_pop)
	);

	tplc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

endmodule
`default_nettype wire
